// File: rtl/utf8_stream_decoder_top_macros.svh
// Assertion macros shared by the checker files.
`ifndef UTF8_STREAM_DECODER_TOP_MACROS_SVH
`define UTF8_STREAM_DECODER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define U8SD_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define U8SD_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

// Next-cycle implication that also holds across reset.
`define U8SD_ASSERT_NEXT_ALWAYS(label, clk, ante, cons, msg) \
    label: assert property (@(posedge clk) (ante) |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/u8sd_pkg.sv
`timescale 1ns / 1ps

package u8sd_pkg;

    localparam int BYTE_W = 8;
    localparam int CP_W   = 31;
    localparam int LEN_W  = 3;
    localparam int PAY_W  = 6;

    // Longest legal sequence; byte count saturates here
    localparam logic [LEN_W-1:0] LEN_MAX = 3'd6;

    // Lead byte classes: mask and match
    localparam logic [BYTE_W-1:0] MSK_ASCII = 8'h80;
    localparam logic [BYTE_W-1:0] MSK_CONT  = 8'hc0;
    localparam logic [BYTE_W-1:0] PAT_CONT  = 8'h80;
    localparam logic [BYTE_W-1:0] MSK_L2    = 8'he0;
    localparam logic [BYTE_W-1:0] PAT_L2    = 8'hc0;
    localparam logic [BYTE_W-1:0] MSK_L3    = 8'hf0;
    localparam logic [BYTE_W-1:0] PAT_L3    = 8'he0;
    localparam logic [BYTE_W-1:0] MSK_L4    = 8'hf8;
    localparam logic [BYTE_W-1:0] PAT_L4    = 8'hf0;
    localparam logic [BYTE_W-1:0] MSK_L5    = 8'hfc;
    localparam logic [BYTE_W-1:0] PAT_L5    = 8'hf8;

    // Payload masks per lead class
    localparam logic [BYTE_W-1:0] PAY_CONT = 8'h3f;
    localparam logic [BYTE_W-1:0] PAY_L2   = 8'h1f;
    localparam logic [BYTE_W-1:0] PAY_L3   = 8'h0f;
    localparam logic [BYTE_W-1:0] PAY_L4   = 8'h07;
    localparam logic [BYTE_W-1:0] PAY_L5   = 8'h03;
    localparam logic [BYTE_W-1:0] PAY_L6   = 8'h01;

    // Follower counts set by each lead class
    localparam logic [LEN_W-1:0] FOL_L2 = 3'd1;
    localparam logic [LEN_W-1:0] FOL_L3 = 3'd2;
    localparam logic [LEN_W-1:0] FOL_L4 = 3'd3;
    localparam logic [LEN_W-1:0] FOL_L5 = 3'd4;
    localparam logic [LEN_W-1:0] FOL_L6 = 3'd5;

    // Result of one decode step
    typedef struct packed {
        logic              emit;
        logic [CP_W-1:0]   code_point;
        logic [LEN_W-1:0]  seq_length;
    } t_result;

endpackage

// File: rtl/u8sd_core.sv
`timescale 1ns / 1ps

module u8sd_core
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_en,
    input  logic [BYTE_W-1:0] i_byte,
    output t_result           o_res
);

    logic [CP_W-1:0]  r_acc, n_acc;
    logic [LEN_W-1:0] r_pend, n_pend;
    logic [LEN_W-1:0] r_cnt, n_cnt;
    logic [LEN_W-1:0] w_len;
    logic [PAY_W-1:0] w_pay;
    logic [CP_W-1:0]  w_shift;

    // Bytes including this one, saturating
    assign w_len = (r_cnt >= LEN_MAX) ? LEN_MAX : r_cnt + 3'd1;

    // Follower payload; non-continuation bytes shift in zeros
    assign w_pay   = ((i_byte & MSK_CONT) == PAT_CONT) ? i_byte[PAY_W-1:0] : '0;
    assign w_shift = {r_acc[CP_W-PAY_W-1:0], w_pay};

    // Decode one byte against the current state
    always_comb begin
        n_acc            = r_acc;
        n_pend           = r_pend;
        n_cnt            = w_len;
        o_res.emit       = 1'b0;
        o_res.code_point = w_shift;
        o_res.seq_length = w_len;
        if ((i_byte & MSK_ASCII) == '0) begin
            // ASCII: emit now, open sequence is kept
            o_res.emit       = 1'b1;
            o_res.code_point = {{(CP_W-BYTE_W){1'b0}}, i_byte};
            n_cnt            = '0;
        end else if (r_pend != '0) begin
            n_acc  = w_shift;
            n_pend = r_pend - 3'd1;
            if (r_pend == 3'd1) begin
                o_res.emit = 1'b1;
                n_cnt      = '0;
            end
        end else begin
            priority if ((i_byte & MSK_L2) == PAT_L2) begin
                n_acc  = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY_L2};
                n_pend = FOL_L2;
            end else if ((i_byte & MSK_L3) == PAT_L3) begin
                n_acc  = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY_L3};
                n_pend = FOL_L3;
            end else if ((i_byte & MSK_L4) == PAT_L4) begin
                n_acc  = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY_L4};
                n_pend = FOL_L4;
            end else if ((i_byte & MSK_L5) == PAT_L5) begin
                n_acc  = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY_L5};
                n_pend = FOL_L5;
            end else begin
                // stray continuation or 0xFC..0xFF: six-byte lead
                n_acc  = {{(CP_W-BYTE_W){1'b0}}, i_byte & PAY_L6};
                n_pend = FOL_L6;
            end
        end
    end

    // Decoder state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_acc  <= '0;
            r_pend <= '0;
            r_cnt  <= '0;
        end else if (i_en) begin
            r_acc  <= n_acc;
            r_pend <= n_pend;
            r_cnt  <= n_cnt;
        end
    end

endmodule

// File: rtl/utf8_stream_decoder_top.sv
`timescale 1ns / 1ps
// UTF-8 stream decoder, lenient legacy form with leads for up to six bytes.
// Input channel: one raw byte per word on i_in_byte, handshake
//   i_in_valid / o_in_ready.
// Output channel: one word per completed character, o_code_point (31 bits)
//   and o_seq_length (bytes since the previous character, 1..6), handshake
//   o_out_valid / i_out_ready. Lead and follower bytes that do not finish a
//   character produce no output word.
// Path: accepted byte to input register, then its character to output register.
// Throughput: one byte per cycle while the output is not stalled; the input
//   register feeds the decode state and the output register on the same edge.
// Stall: while the output word waits, the input register holds its byte and
//   o_in_ready drops once it is full; no word is dropped or repeated.
// Reset (i_rst_n low, synchronous): both registers empty, decode state and
//   byte count cleared; o_in_ready is high right after reset.
module utf8_stream_decoder_top
    import u8sd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [BYTE_W-1:0] i_in_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [CP_W-1:0]   o_code_point,
    output logic [LEN_W-1:0]  o_seq_length
);

    logic              r_in_valid;
    logic [BYTE_W-1:0] r_in_byte;
    logic              r_out_valid;
    logic [CP_W-1:0]   r_code_point;
    logic [LEN_W-1:0]  r_seq_length;
    logic              w_adv;
    t_result           w_res;

    // Input register moves on when the output slot is free or draining
    assign w_adv      = r_in_valid && (!r_out_valid || i_out_ready);
    assign o_in_ready = !r_in_valid || w_adv;

    u8sd_core u_core (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_adv),
        .i_byte  (r_in_byte),
        .o_res   (w_res)
    );

    // Input register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (o_in_ready) begin
            r_in_valid <= i_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_in_ready) begin
            r_in_byte <= i_in_byte;
        end
    end

    // Output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_adv) begin
            r_out_valid <= w_res.emit;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_adv && w_res.emit) begin
            r_code_point <= w_res.code_point;
            r_seq_length <= w_res.seq_length;
        end
    end

    assign o_out_valid  = r_out_valid;
    assign o_code_point = r_code_point;
    assign o_seq_length = r_seq_length;

endmodule

// File: rtl/u8sd_checker.sv
`timescale 1ns / 1ps
`include "utf8_stream_decoder_top_macros.svh"

module u8sd_checker
    import u8sd_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              o_in_ready,
    input logic [BYTE_W-1:0] i_in_byte,
    input logic              o_out_valid,
    input logic              i_out_ready,
    input logic [CP_W-1:0]   o_code_point,
    input logic [LEN_W-1:0]  o_seq_length
);

    // Stalled output word holds
    `U8SD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && !i_out_ready, o_out_valid && $stable(o_code_point) && $stable(o_seq_length), "output word changed under stall")

    // Length is always within one to six
    `U8SD_ASSERT_SAME(a_len_range, i_clk, i_rst_n, o_out_valid, o_seq_length != 3'd0 && o_seq_length != 3'd7, "sequence length out of range")

    // A fresh output word must be traced to an earlier accepted byte
    `U8SD_ASSERT_SAME(a_latency, i_clk, i_rst_n, $rose(o_out_valid), $past(i_in_valid && o_in_ready, 2), "output word without a byte two cycles before")

    // Reset empties both sides
    `U8SD_ASSERT_NEXT_ALWAYS(a_reset, i_clk, !i_rst_n, !o_out_valid && o_in_ready, "registers not empty after reset")

endmodule

bind utf8_stream_decoder_top u8sd_checker u_u8sd_checker (.*);

// File: bench/utf8_decode_checker.sv
`timescale 1ns / 1ps

// Watches both channels of the decoder, predicts each character from the
// accepted bytes and compares every output word against the oldest one due.
module utf8_decode_checker
    import u8sd_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    input  logic              in_ready,
    input  logic [BYTE_W-1:0] in_byte,
    input  logic              out_valid,
    input  logic              out_ready,
    input  logic [CP_W-1:0]   code_point,
    input  logic [LEN_W-1:0]  seq_length,
    output int                error_count,
    output int                chars_waiting
);

    typedef struct packed {
        logic [CP_W-1:0]  code_point;
        logic [LEN_W-1:0] seq_length;
    } t_char;

    // Decode state of the predictor
    logic [CP_W-1:0]  acc_cp;
    logic [LEN_W-1:0] fol_left;
    logic [LEN_W-1:0] bytes_seen;

    t_char chars_due[$];

    initial begin
        error_count   = 0;
        chars_waiting = 0;
        acc_cp        = '0;
        fol_left      = '0;
        bytes_seen    = '0;
    end

    task automatic report(input string msg);
        $display("[%0t] utf8 check: %s", $time, msg);
        error_count++;
    endtask

    // One byte through the lenient decoder; emit marks a finished character
    task automatic decode_byte(
        input  logic [BYTE_W-1:0] b,
        output logic              emit,
        output t_char             ch
    );
        logic [LEN_W-1:0] next_len;
        logic [5:0]       pay;
        next_len = (bytes_seen >= 3'd6) ? 3'd6 : bytes_seen + 3'd1;
        emit          = 1'b0;
        ch.code_point = '0;
        ch.seq_length = next_len;
        if (!b[7]) begin
            // ASCII goes out at once, an open sequence stays open
            emit          = 1'b1;
            ch.code_point = {23'd0, b};
            bytes_seen    = '0;
        end else if (fol_left != 0) begin
            // any high byte counts as follower; non-continuation adds zeros
            pay      = (b[7:6] == 2'b10) ? b[5:0] : 6'd0;
            acc_cp   = {acc_cp[CP_W-7:0], pay};
            fol_left = fol_left - 3'd1;
            if (fol_left == 0) begin
                emit          = 1'b1;
                ch.code_point = acc_cp;
                bytes_seen    = '0;
            end else begin
                bytes_seen = next_len;
            end
        end else begin
            // lead byte; stray continuations and 0xfc..0xff open six bytes
            casez (b)
                8'b110?????: begin
                    acc_cp   = {26'd0, b[4:0]};
                    fol_left = 3'd1;
                end
                8'b1110????: begin
                    acc_cp   = {27'd0, b[3:0]};
                    fol_left = 3'd2;
                end
                8'b11110???: begin
                    acc_cp   = {28'd0, b[2:0]};
                    fol_left = 3'd3;
                end
                8'b111110??: begin
                    acc_cp   = {29'd0, b[1:0]};
                    fol_left = 3'd4;
                end
                default: begin
                    acc_cp   = {30'd0, b[0]};
                    fol_left = 3'd5;
                end
            endcase
            bytes_seen = next_len;
        end
    endtask

    always @(posedge clk) begin
        logic  emit;
        t_char ch;
        t_char due;
        if (!rst_n) begin
            acc_cp     = '0;
            fol_left   = '0;
            bytes_seen = '0;
            chars_due.delete();
        end else begin
            // output side first: a word can never belong to a byte of this edge
            if (out_valid && out_ready) begin
                if (chars_due.size() == 0) begin
                    report($sformatf("word with none due: cp=%h len=%0d",
                                     code_point, seq_length));
                end else begin
                    due = chars_due.pop_front();
                    if (code_point !== due.code_point)
                        report($sformatf("code_point %h, expected %h",
                                         code_point, due.code_point));
                    if (seq_length !== due.seq_length)
                        report($sformatf("seq_length %0d, expected %0d (cp %h)",
                                         seq_length, due.seq_length, due.code_point));
                end
            end
            if (in_valid && in_ready) begin
                decode_byte(in_byte, emit, ch);
                if (emit)
                    chars_due.push_back(ch);
            end
        end
        chars_waiting = chars_due.size();
    end

endmodule

// File: bench/utf8_stream_decoder_top_test.sv
`timescale 1ns / 1ps

module utf8_stream_decoder_top_test;
    import u8sd_pkg::*;

    localparam int RANDOM_BYTES = 650;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 8;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [BYTE_W-1:0] i_in_byte;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [CP_W-1:0]   o_code_point;
    logic [LEN_W-1:0]  o_seq_length;

    int error_count;
    int chars_waiting;
    int cycle_count;
    int burst_left;

    logic [BYTE_W-1:0] stream_bytes[$];

    utf8_stream_decoder_top dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in_valid   (i_in_valid),
        .o_in_ready   (o_in_ready),
        .i_in_byte    (i_in_byte),
        .o_out_valid  (o_out_valid),
        .i_out_ready  (i_out_ready),
        .o_code_point (o_code_point),
        .o_seq_length (o_seq_length)
    );

    utf8_decode_checker checker_i (
        .clk           (i_clk),
        .rst_n         (i_rst_n),
        .in_valid      (i_in_valid),
        .in_ready      (o_in_ready),
        .in_byte       (i_in_byte),
        .out_valid     (o_out_valid),
        .out_ready     (i_out_ready),
        .code_point    (o_code_point),
        .seq_length    (o_seq_length),
        .error_count   (error_count),
        .chars_waiting (chars_waiting)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    // Watchdog
    initial cycle_count = 0;
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("utf8_stream_decoder_top_test: errors");
            $finish;
        end
    end

    // Lead byte opening a sequence of n bytes; n of 6 may be a stray continuation
    function automatic logic [BYTE_W-1:0] lead_byte(input int n);
        case (n)
            1: return 8'($urandom_range(0, 127));
            2: return {3'b110, 5'($urandom)};
            3: return {4'b1110, 4'($urandom)};
            4: return {5'b11110, 3'($urandom)};
            5: return {6'b111110, 2'($urandom)};
            default: begin
                if ($urandom_range(0, 1) == 1)
                    return {6'b111111, 2'($urandom)};
                return {2'b10, 6'($urandom)};
            end
        endcase
    endfunction

    function automatic logic [BYTE_W-1:0] follower_byte();
        return {2'b10, 6'($urandom)};
    endfunction

    // Mostly well-formed characters, some noise and cut-off sequences
    task automatic add_random_chars();
        int kind;
        int n;
        int k;
        kind = $urandom_range(0, 99);
        if (kind < 15) begin
            stream_bytes.push_back(8'($urandom));
        end else if (kind < 25) begin
            n = $urandom_range(2, 6);
            stream_bytes.push_back(lead_byte(n));
            k = $urandom_range(0, n - 2);
            repeat (k) stream_bytes.push_back(follower_byte());
        end else begin
            n = $urandom_range(1, 6);
            stream_bytes.push_back(lead_byte(n));
            repeat (n - 1) stream_bytes.push_back(follower_byte());
        end
    endtask

    // Offer one word in bursts with random gaps; returns on the accepting edge
    task automatic send_byte(input logic [BYTE_W-1:0] b);
        int gap;
        gap = 0;
        if (burst_left == 0) begin
            burst_left = $urandom_range(1, 24);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
        end
        burst_left--;
        @(negedge i_clk);
        if (gap > 0) begin
            i_in_valid = 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        i_in_valid = 1'b1;
        i_in_byte  = b;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    // Receiver: stall pattern of changing density, one long hold-off
    initial begin
        int seg_len;
        int mode;
        int hold_cnt;
        i_out_ready = 1'b0;
        @(posedge i_rst_n);
        repeat (150) begin
            @(negedge i_clk);
            i_out_ready = ($urandom_range(0, 3) != 0);
        end
        // long hold so the decoder backs up into its input
        @(negedge i_clk);
        i_out_ready = 1'b0;
        hold_cnt = 0;
        while (hold_cnt < 90) begin
            @(negedge i_clk);
            hold_cnt++;
        end
        forever begin
            seg_len = $urandom_range(8, 40);
            mode    = $urandom_range(0, 2);
            repeat (seg_len) begin
                @(negedge i_clk);
                case (mode)
                    0: i_out_ready = 1'b1;
                    1: i_out_ready = ($urandom_range(0, 1) == 1);
                    default: i_out_ready = ($urandom_range(0, 3) == 0);
                endcase
            end
        end
    end

    // Stimulus and verdict
    initial begin
        logic [BYTE_W-1:0] directed[$];
        int sent;
        i_rst_n    = 1'b0;
        i_in_valid = 1'b0;
        i_in_byte  = '0;
        burst_left = 0;
        sent       = 0;
        directed = {
            8'h00,                                     // ASCII low end
            8'hc2, 8'ha9,                              // two bytes
            8'hef, 8'hbf, 8'hbf,                       // three bytes, all ones
            8'hf4, 8'h8f, 8'hbf, 8'hbf,                // four bytes
            8'hfb, 8'hbf, 8'h80, 8'h80, 8'h80,         // five-byte lead
            8'hff, 8'hbf, 8'hbf, 8'hbf, 8'hbf, 8'hbf,  // widest code point
            // stray continuation as lead, ASCII inside, non-continuation follower
            8'h80, 8'h7f, 8'hc0, 8'hbf, 8'hbf, 8'hbf, 8'hbf
        };
        repeat (7) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        foreach (directed[j])
            send_byte(directed[j]);

        while (sent < RANDOM_BYTES) begin
            if (stream_bytes.size() == 0)
                add_random_chars();
            send_byte(stream_bytes.pop_front());
            sent++;
        end

        @(negedge i_clk);
        i_in_valid = 1'b0;
        wait (chars_waiting == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("utf8_stream_decoder_top_test: clean");
        else
            $display("utf8_stream_decoder_top_test: errors");
        $finish;
    end

endmodule
